[hw/rtl/pfa_pkg.sv]
// Shared types and constants of the page frame allocator.
// Used by pfa_front, pfa_back and page_frame_allocator; depends on nothing.
package pfa_pkg;

    localparam int FREE_DEPTH_DEF   = 1024;
    localparam int REGION_DEPTH_DEF = 16;
    localparam int FRAME_BITS_DEF   = 36;

    // request opcodes as they arrive on the input channel
    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_REGION = 2'd2;

    // request kind after classification; a region with no pages is a no-op
    typedef enum logic [1:0] {
        K_ALLOC  = 2'd0,
        K_FREE   = 2'd1,
        K_REGION = 2'd2,
        K_NOP    = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_OOM         = 2'd1,
        ST_FREE_FULL   = 2'd2,
        ST_REGION_FULL = 2'd3
    } status_t;

    typedef enum logic {
        BK_EXEC = 1'b0,
        BK_POP  = 1'b1
    } back_state_t;

    // head of the request queue as the back end sees it
    typedef struct packed {
        logic      valid;
        req_kind_t kind;
    } q_ctrl_t;

endpackage

[hw/rtl/page_frame_allocator.sv]
// Page frame allocator: an accepted request is queued in the front end, then
// executed into the result register (a free stack allocation also passes
// the registered memory read). One request per cycle while out_stall is low,
// but a free stack pop adds a BK_POP state. Reset clears both stack counts,
// the request queue and the result valid flag; no clearing pass is needed.
module page_frame_allocator #(
    parameter int FREE_DEPTH   = pfa_pkg::FREE_DEPTH_DEF,
    parameter int REGION_DEPTH = pfa_pkg::REGION_DEPTH_DEF,
    parameter int FRAME_BITS   = pfa_pkg::FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  logic [FRAME_BITS-1:0] frame_number,
    input  logic [FRAME_BITS-1:0] region_base,
    input  logic [FRAME_BITS-1:0] region_pages,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [FRAME_BITS-1:0] granted_frame,
    output logic [1:0]            status
);
    import pfa_pkg::*;

    // Front end takes a request, turns the opcode into a request kind
    // (a region with zero pages becomes a no-op) and queues it.
    // Back end drains the queue one request at a time, updates the free
    // stack memory or the region stack and loads the result register.
    q_ctrl_t               q_ctrl;
    logic [FRAME_BITS-1:0] q_arg;
    logic [FRAME_BITS-1:0] q_pages;
    logic                  q_pop;

    pfa_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .frame_number (frame_number),
        .region_base  (region_base),
        .region_pages (region_pages),
        .q_ctrl       (q_ctrl),
        .q_arg        (q_arg),
        .q_pages      (q_pages),
        .q_pop        (q_pop)
    );

    // Back end holds the result while out_stall is high and keeps the
    // queue's head in place until the result slot frees up.
    pfa_back #(
        .FREE_DEPTH   (FREE_DEPTH),
        .REGION_DEPTH (REGION_DEPTH),
        .FRAME_BITS   (FRAME_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_ctrl        (q_ctrl),
        .q_arg         (q_arg),
        .q_pages       (q_pages),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted_frame (granted_frame),
        .status        (status)
    );

endmodule

[hw/rtl/pfa_front.sv]
// Front end of the page frame allocator: accepts requests, classifies them
// and holds them in a two-entry queue. Depends on pfa_pkg.
module pfa_front #(
    parameter int FRAME_BITS = pfa_pkg::FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  logic [FRAME_BITS-1:0] frame_number,
    input  logic [FRAME_BITS-1:0] region_base,
    input  logic [FRAME_BITS-1:0] region_pages,
    output pfa_pkg::q_ctrl_t      q_ctrl,
    output logic [FRAME_BITS-1:0] q_arg,
    output logic [FRAME_BITS-1:0] q_pages,
    input  logic                  q_pop
);
    import pfa_pkg::*;

    req_kind_t             kind_mem [2];
    logic [FRAME_BITS-1:0] arg_mem  [2];
    logic [FRAME_BITS-1:0] pages_mem[2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    req_kind_t  kind_in;
    logic [FRAME_BITS-1:0] arg_in;

    // classify the request
    always_comb
    begin
        kind_in = K_NOP;
        arg_in  = frame_number;
        case (opcode)
            OP_ALLOC:  kind_in = K_ALLOC;
            OP_FREE:   kind_in = K_FREE;
            OP_REGION:
            begin
                arg_in  = region_base;
                kind_in = (region_pages != '0) ? K_REGION : K_NOP;
            end
            default:   kind_in = K_NOP;
        endcase
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_mem[wr_ptr_reg]  <= kind_in;
            arg_mem[wr_ptr_reg]   <= arg_in;
            pages_mem[wr_ptr_reg] <= region_pages;
        end
    end

    assign q_ctrl.valid = (count_reg != 2'd0);
    assign q_ctrl.kind  = kind_mem[rd_ptr_reg];
    assign q_arg        = arg_mem[rd_ptr_reg];
    assign q_pages      = pages_mem[rd_ptr_reg];

endmodule

[hw/rtl/pfa_back.sv]
// Back end of the page frame allocator: free stack memory, region stack,
// execution sequencer and the result register. Depends on pfa_pkg.
module pfa_back #(
    parameter int FREE_DEPTH   = pfa_pkg::FREE_DEPTH_DEF,
    parameter int REGION_DEPTH = pfa_pkg::REGION_DEPTH_DEF,
    parameter int FRAME_BITS   = pfa_pkg::FRAME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfa_pkg::q_ctrl_t      q_ctrl,
    input  logic [FRAME_BITS-1:0] q_arg,
    input  logic [FRAME_BITS-1:0] q_pages,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [FRAME_BITS-1:0] granted_frame,
    output logic [1:0]            status
);
    import pfa_pkg::*;

    localparam int CNT_W  = $clog2(FREE_DEPTH + 1);
    localparam int FIDX_W = $clog2(FREE_DEPTH);
    localparam int RCNT_W = $clog2(REGION_DEPTH + 1);
    localparam int RIDX_W = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;

    logic [FRAME_BITS-1:0] free_mem[FREE_DEPTH];
    logic [FRAME_BITS-1:0] rd_data_reg;
    logic [FRAME_BITS-1:0] region_next_frame[REGION_DEPTH];
    logic [FRAME_BITS-1:0] region_pages_left[REGION_DEPTH];

    back_state_t state_reg, state_next;
    logic [CNT_W-1:0]  free_count_reg, free_count_next, cnt_dec;
    logic [RCNT_W-1:0] region_count_reg, region_count_next, rcnt_dec;

    logic                  out_valid_reg, out_valid_next;
    logic [FRAME_BITS-1:0] grant_reg, grant_next;
    status_t               status_reg, status_next;

    logic                  out_free, go, load;
    logic                  rd_en, mem_wr_en, rg_wr_en;
    logic [RIDX_W-1:0]     region_top, rg_wr_idx;
    logic [FRAME_BITS-1:0] top_frame, top_left, rg_frame_w, rg_left_w;
    logic [FRAME_BITS-1:0] load_grant;
    status_t               load_status;

    assign out_free   = !out_valid_reg || !out_stall;
    assign go         = q_ctrl.valid && out_free;
    assign cnt_dec    = free_count_reg - CNT_W'(1);
    assign rcnt_dec   = region_count_reg - RCNT_W'(1);
    assign region_top = rcnt_dec[RIDX_W-1:0];
    assign top_frame  = region_next_frame[region_top];
    assign top_left   = region_pages_left[region_top];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_EXEC:
                if (go && q_ctrl.kind == K_ALLOC && free_count_reg != '0)
                    state_next = BK_POP;
            BK_POP:
                if (out_free)
                    state_next = BK_EXEC;
            default: state_next = BK_EXEC;
        endcase
    end

    // actions
    always_comb
    begin
        q_pop             = 1'b0;
        rd_en             = 1'b0;
        mem_wr_en         = 1'b0;
        rg_wr_en          = 1'b0;
        rg_wr_idx         = region_top;
        rg_frame_w        = q_arg;
        rg_left_w         = q_pages;
        load              = 1'b0;
        load_grant        = '0;
        load_status       = ST_OK;
        free_count_next   = free_count_reg;
        region_count_next = region_count_reg;
        case (state_reg)
            BK_EXEC:
                if (go)
                begin
                    q_pop = 1'b1;
                    case (q_ctrl.kind)
                        K_ALLOC:
                            if (free_count_reg != '0)
                            begin
                                // pop the free stack; data arrives next cycle
                                rd_en           = 1'b1;
                                free_count_next = cnt_dec;
                            end
                            else if (region_count_reg != '0)
                            begin
                                load       = 1'b1;
                                load_grant = top_frame;
                                rg_wr_en   = 1'b1;
                                rg_frame_w = top_frame + FRAME_BITS'(1);
                                rg_left_w  = top_left - FRAME_BITS'(1);
                                if (rg_left_w == '0)
                                    region_count_next = rcnt_dec;
                            end
                            else
                            begin
                                load        = 1'b1;
                                load_status = ST_OOM;
                            end
                        K_FREE:
                        begin
                            load = 1'b1;
                            if (free_count_reg < CNT_W'(FREE_DEPTH))
                            begin
                                mem_wr_en       = 1'b1;
                                free_count_next = free_count_reg + CNT_W'(1);
                            end
                            else
                                load_status = ST_FREE_FULL;
                        end
                        K_REGION:
                        begin
                            load = 1'b1;
                            if (region_count_reg < RCNT_W'(REGION_DEPTH))
                            begin
                                rg_wr_en          = 1'b1;
                                rg_wr_idx         = region_count_reg[RIDX_W-1:0];
                                region_count_next = region_count_reg + RCNT_W'(1);
                            end
                            else
                                load_status = ST_REGION_FULL;
                        end
                        default: load = 1'b1;
                    endcase
                end
            BK_POP:
                if (out_free)
                begin
                    load       = 1'b1;
                    load_grant = rd_data_reg;
                end
            default: ;
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
        grant_next     = load ? load_grant : grant_reg;
        status_next    = load ? load_status : status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= BK_EXEC;
            free_count_reg   <= '0;
            region_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            free_count_reg   <= free_count_next;
            region_count_reg <= region_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grant_reg  <= grant_next;
        status_reg <= status_next;
    end

    // free stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            free_mem[free_count_reg[FIDX_W-1:0]] <= q_arg;
        if (rd_en)
            rd_data_reg <= free_mem[cnt_dec[FIDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (rg_wr_en)
        begin
            region_next_frame[rg_wr_idx] <= rg_frame_w;
            region_pages_left[rg_wr_idx] <= rg_left_w;
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted_frame = grant_reg;
    assign status        = status_reg;

    a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= CNT_W'(FREE_DEPTH))
        else $error("free stack count beyond depth");

    a_region_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        region_count_reg <= RCNT_W'(REGION_DEPTH))
        else $error("region stack count beyond depth");

    a_pop_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> state_reg == BK_POP)
        else $error("free stack read not followed by pop cycle");

    a_pop_needs_request: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_ctrl.valid && state_reg == BK_EXEC)
        else $error("queue popped while empty or busy");

    a_failed_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> grant_reg == '0)
        else $error("nonzero frame on a failed request");

endmodule

[tb/sv/tb_page_frame_allocator.sv]
`timescale 1ns / 100ps
// Self-checking bench for page_frame_allocator: directed and random requests are
// predicted by a free-stack / region-stack model and checked in order.
// Depends on pfa_pkg and the page_frame_allocator RTL.
module tb_page_frame_allocator;
    import pfa_pkg::*;

    localparam int FB           = FRAME_BITS_DEF;
    localparam int FREE_SLOTS   = FREE_DEPTH_DEF;
    localparam int REGION_SLOTS = REGION_DEPTH_DEF;

    // the opcode field has one code with no meaning; the block answers it with ok
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_REQS   = 1600;
    localparam int TAIL_REQS     = 200;   // no idling on either side for this many
    localparam int LONG_HOLD_AT  = 400;   // result count that starts the long hold-off
    localparam int LONG_HOLD     = 80;
    localparam int DRAIN_AT      = 800;   // request count that pauses the sender
    localparam int SETTLE_CYCLES = 16;

    localparam logic [FB-1:0] FRAME_MAX = '1;

    typedef struct {
        logic [1:0]    opcode;
        logic [FB-1:0] frame_number;
        logic [FB-1:0] region_base;
        logic [FB-1:0] region_pages;
    } pfa_req_t;

    typedef struct {
        logic [FB-1:0] granted_frame;
        status_t       status;
    } pfa_result_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          in_valid     = 1'b0;
    logic          in_stall;
    logic [1:0]    opcode       = OP_ALLOC;
    logic [FB-1:0] frame_number = '0;
    logic [FB-1:0] region_base  = '0;
    logic [FB-1:0] region_pages = '0;
    logic          out_valid;
    logic          out_stall    = 1'b0;
    logic [FB-1:0] granted_frame;
    logic [1:0]    status;

    page_frame_allocator #(
        .FREE_DEPTH   (FREE_SLOTS),
        .REGION_DEPTH (REGION_SLOTS),
        .FRAME_BITS   (FB)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .frame_number  (frame_number),
        .region_base   (region_base),
        .region_pages  (region_pages),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted_frame (granted_frame),
        .status        (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Allocator model: its own free stack and region stack, advanced once
    // per accepted request.
    // ------------------------------------------------------------------
    logic [FB-1:0] free_frames [FREE_SLOTS];
    int unsigned   free_level = 0;
    logic [FB-1:0] region_next [REGION_SLOTS];
    logic [FB-1:0] region_left [REGION_SLOTS];
    int unsigned   region_level = 0;

    function automatic pfa_result_t serve_request(input pfa_req_t r);
        pfa_result_t res;
        int unsigned top;
        res.granted_frame = '0;
        res.status        = ST_OK;
        case (r.opcode)
            OP_ALLOC:
            begin
                // freed frames win over fresh region frames
                if (free_level > 0)
                begin
                    free_level--;
                    res.granted_frame = free_frames[free_level];
                end
                else if (region_level > 0)
                begin
                    top = region_level - 1;
                    res.granted_frame = region_next[top];
                    region_next[top] = region_next[top] + FB'(1);   // wraps at the top frame
                    region_left[top] = region_left[top] - FB'(1);
                    if (region_left[top] == '0)
                        region_level = top;
                end
                else
                    res.status = ST_OOM;
            end
            OP_FREE:
            begin
                // duplicates are stored again; a full stack drops the frame
                if (free_level < FREE_SLOTS)
                begin
                    free_frames[free_level] = r.frame_number;
                    free_level++;
                end
                else
                    res.status = ST_FREE_FULL;
            end
            OP_REGION:
            begin
                // an empty region is a no-op with status ok
                if (r.region_pages != '0)
                begin
                    if (region_level < REGION_SLOTS)
                    begin
                        region_next[region_level] = r.region_base;
                        region_left[region_level] = r.region_pages;
                        region_level++;
                    end
                    else
                        res.status = ST_REGION_FULL;
                end
            end
            default:
                ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request generation. Track a rough free-stack level so that the stack
    // can be driven to full late in the run.
    // ------------------------------------------------------------------
    pfa_req_t    request_q[$];
    pfa_result_t grant_expect_q[$];
    int unsigned gen_free_level = 0;
    int unsigned total_reqs     = 0;
    int unsigned errors         = 0;

    function automatic logic [FB-1:0] rand_frame();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return FRAME_MAX;
            default: return w[FB-1:0];
        endcase
    endfunction

    // mostly small regions so they run out; now and then empty or huge
    function automatic logic [FB-1:0] region_size();
        int unsigned k;
        k = $urandom_range(0, 31);
        if (k == 0)
            return '0;
        else if (k == 1)
            return FRAME_MAX;
        else if (k == 2)
            return rand_frame();
        else
            return FB'($urandom_range(1, 6));
    endfunction

    // bases near the top frame make the region wrap
    function automatic logic [FB-1:0] region_start();
        if ($urandom_range(0, 3) == 0)
            return FRAME_MAX - FB'($urandom_range(0, 4));
        else
            return rand_frame();
    endfunction

    function automatic void queue_req(input logic [1:0] op, input logic [FB-1:0] frame,
                                      input logic [FB-1:0] base, input logic [FB-1:0] pages);
        pfa_req_t r;
        r.opcode       = op;
        r.frame_number = frame;
        r.region_base  = base;
        r.region_pages = pages;
        request_q.push_back(r);
        if (op == OP_FREE && gen_free_level < FREE_SLOTS)
            gen_free_level++;
        else if (op == OP_ALLOC && gen_free_level > 0)
            gen_free_level--;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next request; hold it while the block stalls.
    // Idle gaps come only after an accepted request, so valid never
    // reacts to stall.
    // ------------------------------------------------------------------
    pfa_req_t    cur_req;
    int unsigned accepted   = 0;
    int unsigned send_gap   = 0;
    int unsigned tx_rate    = 0;
    bit          drain_wait = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            opcode       <= OP_ALLOC;
            frame_number <= '0;
            region_base  <= '0;
            region_pages <= '0;
            send_gap     = 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                grant_expect_q.push_back(serve_request(cur_req));
                accepted++;
                if (accepted % 64 == 0)
                    tx_rate = $urandom_range(0, 3);
                // pause once until every result is back
                if (accepted == DRAIN_AT)
                    drain_wait = 1'b1;
                if (request_q.size() > TAIL_REQS && $urandom_range(0, 7) < tx_rate)
                    send_gap = $urandom_range(1, 9);
            end
            if (drain_wait && grant_expect_q.size() == 0)
                drain_wait = 1'b0;
            if (send_gap > 0 || drain_wait || request_q.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                in_valid <= 1'b0;
            end
            else
            begin
                cur_req = request_q.pop_front();
                in_valid     <= 1'b1;
                opcode       <= cur_req.opcode;
                frame_number <= cur_req.frame_number;
                region_base  <= cur_req.region_base;
                region_pages <= cur_req.region_pages;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each accepted result against the oldest prediction,
    // then decide the stall for the next cycle. One long hold-off fills
    // the block so that it stalls its input.
    // ------------------------------------------------------------------
    pfa_result_t want;
    int unsigned results_seen   = 0;
    int unsigned rx_hold        = 0;
    int unsigned rx_rate        = 0;
    bit          long_hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_hold   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (results_seen % 64 == 0)
                    rx_rate = $urandom_range(0, 3);
                if (grant_expect_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, granted_frame %h status %0d",
                             $time, granted_frame, status);
                end
                else
                begin
                    want = grant_expect_q.pop_front();
                    if (granted_frame !== want.granted_frame)
                    begin
                        errors++;
                        $display("%0t: granted_frame expected %h actual %h",
                                 $time, want.granted_frame, granted_frame);
                    end
                    if (status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                    end
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_stall <= 1'b1;
            end
            else if (!long_hold_done && results_seen >= LONG_HOLD_AT)
            begin
                long_hold_done = 1'b1;
                rx_hold = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (results_seen + TAIL_REQS < total_reqs && $urandom_range(0, 7) < rx_rate)
            begin
                rx_hold = $urandom_range(0, 8);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned n_random;
        int unsigned len;
        int unsigned seg;
        int unsigned k;
        bit          filled;
        n_random = 0;
        filled   = 1'b0;

        // directed: empty allocator, field extremes, wrap, unused opcode,
        // duplicate free, free stack served before regions
        queue_req(OP_ALLOC,  FRAME_MAX, FRAME_MAX, FRAME_MAX);   // out of memory
        queue_req(OP_FREE,   '0,        FRAME_MAX, FRAME_MAX);
        queue_req(OP_FREE,   FRAME_MAX, '0,        '0);
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_REGION, '0,        36'h123,   '0);          // empty region
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_REGION, '0,        FRAME_MAX - FB'(1), 36'd3); // wraps to frame 0
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_UNUSED, FRAME_MAX, FRAME_MAX, FRAME_MAX);
        queue_req(OP_UNUSED, '0,        '0,        '0);
        queue_req(OP_FREE,   36'h5,     '0,        '0);
        queue_req(OP_FREE,   36'h5,     '0,        '0);
        queue_req(OP_REGION, '0,        36'h100,   36'd2);
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_FREE,   36'habc,   '0,        '0);
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_ALLOC,  '0,        '0,        '0);
        queue_req(OP_ALLOC,  '0,        '0,        '0);

        // random: bursts of well-formed traffic with a share of noise
        while (n_random < RANDOM_REQS)
        begin
            if (!filled && n_random + (FREE_SLOTS - gen_free_level) + 3 >= RANDOM_REQS)
            begin
                // fill the free stack to the brim, then overflow it a few times
                filled = 1'b1;
                len = FREE_SLOTS - gen_free_level + 3;
                for (k = 0; k < len; k++)
                    queue_req(OP_FREE, rand_frame(), rand_frame(), rand_frame());
            end
            else
            begin
                seg = $urandom_range(0, 19);
                if (seg < 6)
                begin
                    len = $urandom_range(1, 24);
                    for (k = 0; k < len; k++)
                        queue_req(OP_FREE, rand_frame(), rand_frame(), rand_frame());
                end
                else if (seg < 12)
                begin
                    len = $urandom_range(1, 24);
                    for (k = 0; k < len; k++)
                        queue_req(OP_ALLOC, rand_frame(), rand_frame(), rand_frame());
                end
                else if (seg < 16)
                begin
                    len = $urandom_range(1, 4);
                    for (k = 0; k < len; k++)
                        queue_req(OP_REGION, rand_frame(), region_start(), region_size());
                end
                else if (seg < 18)
                begin
                    len = $urandom_range(1, 8);
                    for (k = 0; k < len; k++)
                        queue_req(2'($urandom_range(0, 3)), rand_frame(), rand_frame(),
                                  rand_frame());
                end
                else if (seg == 18)
                begin
                    // one more region than the table holds
                    len = REGION_SLOTS + 1;
                    for (k = 0; k < len; k++)
                        queue_req(OP_REGION, rand_frame(), region_start(),
                                  FB'($urandom_range(1, 3)));
                end
                else
                begin
                    // drain up to 60 frames of the free stack, then 1 to 20 more allocations
                    len = (gen_free_level < 60 ? gen_free_level : 60) + $urandom_range(1, 20);
                    for (k = 0; k < len; k++)
                        queue_req(OP_ALLOC, rand_frame(), rand_frame(), rand_frame());
                end
            end
            n_random += len;
        end
        total_reqs = request_q.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted < total_reqs)
            @(posedge clk);
        while (grant_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (grant_expect_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, grant_expect_q.size());
        end
        if (errors == 0)
            $display("page_frame_allocator verification clean");
        else
            $display("page_frame_allocator verification failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("page_frame_allocator verification failed");
        $finish;
    end

endmodule
